// ===== src/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Reply checker package
// Types, constants and helper functions shared by the reply checker files.
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam int DEFAULT_MAX_FRAME = 64;
	localparam int BYTE_W            = 8;
	localparam int CNT_W             = 16;
	localparam int LEN_W             = 7;
	localparam int MIN_FRAME         = 5;

	localparam logic [15:0]       CRC_INIT = 16'hFFFF;
	localparam logic [15:0]       CRC_POLY = 16'hA001;
	localparam logic [BYTE_W-1:0] EXC_BIT  = 8'h80;

	localparam logic [BYTE_W-1:0] FC_READ_COILS      = 8'd1;
	localparam logic [BYTE_W-1:0] FC_READ_DISCRETE   = 8'd2;
	localparam logic [BYTE_W-1:0] FC_READ_HOLDING    = 8'd3;
	localparam logic [BYTE_W-1:0] FC_READ_INPUT      = 8'd4;
	localparam logic [BYTE_W-1:0] FC_WRITE_COIL      = 8'd5;
	localparam logic [BYTE_W-1:0] FC_WRITE_REGISTER  = 8'd6;
	localparam logic [BYTE_W-1:0] FC_WRITE_COILS     = 8'd15;
	localparam logic [BYTE_W-1:0] FC_WRITE_REGISTERS = 8'd16;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_WRONG_ID  = 3'd2,
		ST_CRC_FAIL  = 3'd3,
		ST_EXCEPTION = 3'd4,
		ST_ILLEGAL   = 3'd5
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   function_code;
		logic [LEN_W-1:0]    frame_length;
		logic [CNT_W-1:0]    success_count;
		logic [CNT_W-1:0]    failure_count;
		logic [CNT_W-1:0]    exception_count;
		logic [CNT_W-1:0]    retry_count;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
		logic [BYTE_W-1:0] expected_id;
	} beat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [BYTE_W-1:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic legal_function(input logic [BYTE_W-1:0] f);
		logic ok;
		case (f) inside
			FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
			FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGISTERS: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== src/mrrc_if.sv =====
// ----------------------------------------------------------------------------
// Reply checker channels
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [7:0] expected_id;

	modport source (output valid, output data_byte, output last_byte, output expected_id,
		input ready);
	modport sink (input valid, input data_byte, input last_byte, input expected_id,
		output ready);
endinterface

interface mrrc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  function_code;
	logic [6:0]  frame_length;
	logic [15:0] success_count;
	logic [15:0] failure_count;
	logic [15:0] exception_count;
	logic [15:0] retry_count;

	modport source (output valid, output status, output function_code, output frame_length,
		output success_count, output failure_count, output exception_count,
		output retry_count, input ready);
	modport sink (input valid, input status, input function_code, input frame_length,
		input success_count, input failure_count, input exception_count,
		input retry_count, output ready);
endinterface

// ===== src/mrrc_core.sv =====
// ----------------------------------------------------------------------------
// Reply checker core
// Per-frame CRC, byte count and header capture, status decision and counters.
// ----------------------------------------------------------------------------
module mrrc_core import mrrc_pkg::*; #(
	parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  beat_t   beat,
	output logic    push,
	output result_t result
);

	localparam int CW = $clog2(MAX_FRAME + 1);

	logic [15:0]       crc_q, crc_n;
	logic [CW-1:0]     cnt_q, cnt_n;
	logic              ovf_q, ovf_n;
	logic [BYTE_W-1:0] first_q, first_n;
	logic [BYTE_W-1:0] func_q, func_n;
	logic [BYTE_W-1:0] d0_q, d0_n;
	logic [BYTE_W-1:0] d1_q, d1_n;
	logic [CNT_W-1:0]  ok_q, ok_n;
	logic [CNT_W-1:0]  fail_q, fail_n;
	logic [CNT_W-1:0]  exc_q, exc_n;
	logic [CNT_W-1:0]  retry_q, retry_n;
	status_t           status;

	always_comb begin
		crc_n   = crc_q;
		cnt_n   = cnt_q;
		ovf_n   = ovf_q;
		first_n = first_q;
		func_n  = func_q;
		d0_n    = d0_q;
		d1_n    = d1_q;
		if (cnt_q == CW'(MAX_FRAME)) begin
			ovf_n = 1'b1;
		end else begin
			if (cnt_q >= CW'(2)) begin
				crc_n = crc_byte(crc_q, d0_q);
			end
			d0_n = d1_q;
			d1_n = beat.data_byte;
			if (cnt_q == '0) begin
				first_n = beat.data_byte;
			end
			if (cnt_q == CW'(1)) begin
				func_n = beat.data_byte;
			end
			cnt_n = cnt_q + CW'(1);
		end

		if (cnt_n < CW'(MIN_FRAME) || ovf_n) begin
			status = ST_SHORT;
		end else if (first_n != beat.expected_id) begin
			status = ST_WRONG_ID;
		end else if (d0_n != crc_n[7:0] || d1_n != crc_n[15:8]) begin
			status = ST_CRC_FAIL;
		end else if ((func_n & EXC_BIT) == EXC_BIT) begin
			status = ST_EXCEPTION;
		end else if (!legal_function(func_n)) begin
			status = ST_ILLEGAL;
		end else begin
			status = ST_OK;
		end

		ok_n    = ok_q;
		fail_n  = fail_q;
		exc_n   = exc_q;
		retry_n = retry_q;
		if (status == ST_OK) begin
			ok_n    = ok_q + CNT_W'(1);
			retry_n = '0;
		end else begin
			if (status == ST_EXCEPTION) begin
				exc_n = exc_q + CNT_W'(1);
			end
			fail_n  = fail_q + CNT_W'(1);
			retry_n = retry_q + CNT_W'(1);
		end

		result.status          = status;
		result.function_code   = func_n;
		result.frame_length    = LEN_W'(cnt_n);
		result.success_count   = ok_n;
		result.failure_count   = fail_n;
		result.exception_count = exc_n;
		result.retry_count     = retry_n;
	end

	assign push = accept && beat.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			first_q <= '0;
			func_q  <= '0;
			d0_q    <= '0;
			d1_q    <= '0;
			ok_q    <= '0;
			fail_q  <= '0;
			exc_q   <= '0;
			retry_q <= '0;
		end else if (accept) begin
			if (beat.last_byte) begin
				crc_q   <= CRC_INIT;
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
				first_q <= '0;
				func_q  <= '0;
				d0_q    <= '0;
				d1_q    <= '0;
				ok_q    <= ok_n;
				fail_q  <= fail_n;
				exc_q   <= exc_n;
				retry_q <= retry_n;
			end else begin
				crc_q   <= crc_n;
				cnt_q   <= cnt_n;
				ovf_q   <= ovf_n;
				first_q <= first_n;
				func_q  <= func_n;
				d0_q    <= d0_n;
				d1_q    <= d1_n;
			end
		end
	end

	// The byte count never passes the buffer size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_FRAME))
		else $error("byte count beyond buffer size");

	// Overflow can only be flagged once the buffer is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CW'(MAX_FRAME))
		else $error("overflow flagged with buffer not full");

	// A good reply clears the retry counter.
	a_retry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push && result.status == ST_OK |=> retry_q == '0)
		else $error("retry counter not cleared after a good reply");

	// Frame state starts afresh after the final byte.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> cnt_q == '0 && crc_q == CRC_INIT && !ovf_q)
		else $error("frame state not cleared after final byte");

endmodule

// ===== src/modbus_rtu_reply_checker.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU reply checker
// Byte-wise reply validation with CRC-16 and running reply counters.
// ----------------------------------------------------------------------------
// The block takes one reply byte per beat and can accept a beat in every clock
// cycle. Each beat is fully processed in the cycle it is accepted: the CRC-16
// update of one byte, the header capture and, on the final byte, the status
// decision and counter update all fit between the frame state registers and
// the result register. The result of a frame appears on the output channel in
// the cycle after its final byte if the output register is free or being taken;
// else it waits in a second result register, so the input keeps accepting beats
// while one result waits to be taken; input ready drops only when both are full.
module modbus_rtu_reply_checker import mrrc_pkg::*; #(
	parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
	input logic          clk,
	input logic          arst_n,
	mrrc_byte_if.sink    rx,
	mrrc_result_if.source rsp
);

	logic    accept;
	logic    push;
	beat_t   beat;
	result_t result;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign rx.ready = !skid_valid_q;
	assign accept   = rx.valid && rx.ready;
	assign pop      = out_valid_q && rsp.ready;

	assign beat.data_byte   = rx.data_byte;
	assign beat.last_byte   = rx.last_byte;
	assign beat.expected_id = rx.expected_id;

	mrrc_core #(
		.MAX_FRAME(MAX_FRAME)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.beat  (beat),
		.push  (push),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.function_code   = out_q.function_code;
	assign rsp.frame_length    = out_q.frame_length;
	assign rsp.success_count   = out_q.success_count;
	assign rsp.failure_count   = out_q.failure_count;
	assign rsp.exception_count = out_q.exception_count;
	assign rsp.retry_count     = out_q.retry_count;

	// The second result register is only used while the first one is held.
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("second result register filled with the first one empty");

	// A final byte accepted into a free output shows up in the next cycle.
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("result of a final byte lost");

	// A result waiting in the second register moves forward when the first is taken.
	a_skid_move: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q)
		else $error("queued result not forwarded");

endmodule
